// ===== design/display_frame_pacer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Display frame pacer assertion macros
// Shared concurrent assertion forms, clocked on aclk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_FRAME_PACER_UNIT_DEFINES_SVH
`define DISPLAY_FRAME_PACER_UNIT_DEFINES_SVH

// same-cycle implication
`define DFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Display frame pacer package
// Field widths, command and register codes, controller command type.
// ----------------------------------------------------------------------------
package dfp_pkg;

    localparam int TAG_W      = 8;
    localparam int TIME_W     = 32;
    localparam int LIMIT_W    = 4;
    localparam int GRACE_W    = 9;
    localparam int DROP_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 16;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE_TIME  = 1'b1;

    localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RESET = 4'd3;
    localparam logic [GRACE_W-1:0] GRACE_RESET       = 9'd0;
    localparam logic [DROP_W-1:0]  DROP_MAX          = 3'd7;

    typedef struct packed {
        logic accept;
        logic commit;
    } dfp_cmd_t;

endpackage

// ===== design/display_frame_pacer_unit.sv =====
// ----------------------------------------------------------------------------
// Display frame pacer unit
// Paces decoded frames to display ticks with a token budget and grace time.
// ----------------------------------------------------------------------------
// Input stream: one transfer per event. s_tuser selects a frame arrival or a
// display tick; s_tdata carries the frame tag and the current time.
// Output stream: exactly one result transfer per input transfer, carrying
// whether a frame is shown, its tag, and how many queued frames were dropped.
// Configuration: cfg_wr_en with cfg_index 0 writes the queue limit, index 1
// the grace time; write only while no event is in flight.
// Timing: the event is captured into the item registers on the input transfer,
// the frame ring memories are read through their registered read ports, and
// the execute step then registers the result.
// The unit works on one event at a time; the next event is taken while the
// previous result still waits in the output register.
// Reset: tokens, queue pointers and last show time clear, the queue limit
// returns to 3 and the grace time to 0; the ring memories are not cleared.
// Stall: a result held by a low m_tready stays stable; an event already taken
// waits in the execute step until the output register frees.
// ----------------------------------------------------------------------------
module display_frame_pacer_unit #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dfp_pkg::S_TDATA_W-1:0]   s_tdata,   // frame_tag[7:0], now_time[39:8]
    input  logic                            s_tuser,   // cmd[0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dfp_pkg::M_TDATA_W-1:0]   m_tdata,   // show_tag[7:0], dropped_count[10:8]
    output logic                            m_tuser,   // show_valid[0]
    input  logic                            cfg_wr_en,
    input  logic [dfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dfp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    dfp_pkg::dfp_cmd_t           cmd;
    logic                        out_show;
    logic [dfp_pkg::TAG_W-1:0]   out_tag;
    logic [dfp_pkg::DROP_W-1:0]  out_drop;

    dfp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dfp_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_cmd    (s_tuser),
        .in_tag    (s_tdata[7:0]),
        .in_time   (s_tdata[39:8]),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_show  (out_show),
        .out_tag   (out_tag),
        .out_drop  (out_drop)
    );

    assign m_tdata = {5'b0, out_drop, out_tag};
    assign m_tuser = out_show;

endmodule

// ===== design/dfp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/dfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Display frame pacer controller
// Sequences accept and execute steps and owns the result valid flag.
// ----------------------------------------------------------------------------
module dfp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dfp_pkg::dfp_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd.accept   = 1'b0;
        cmd.commit   = 1'b0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

// ===== design/dfp_datapath.sv =====
// ----------------------------------------------------------------------------
// Display frame pacer datapath
// Token and queue state, frame ring memories, show and drop decisions.
// ----------------------------------------------------------------------------
module dfp_datapath #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dfp_pkg::dfp_cmd_t               cmd,
    input  logic                            in_cmd,
    input  logic [dfp_pkg::TAG_W-1:0]       in_tag,
    input  logic [dfp_pkg::TIME_W-1:0]      in_time,
    input  logic                            cfg_wr_en,
    input  logic [dfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dfp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output logic                            out_show,
    output logic [dfp_pkg::TAG_W-1:0]       out_tag,
    output logic [dfp_pkg::DROP_W-1:0]      out_drop
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = $clog2(QUEUE_DEPTH + 2);
    localparam int SW = CW + 1;
    localparam int DW = CW + 3;

    logic [dfp_pkg::LIMIT_W-1:0] limit_reg;
    logic [dfp_pkg::GRACE_W-1:0] grace_reg;
    logic [TW-1:0]               tok_reg, tok_next;
    logic [AW-1:0]               head_reg, head_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [dfp_pkg::TIME_W-1:0]  last_reg, last_next;

    logic                        item_cmd_reg;
    logic [dfp_pkg::TAG_W-1:0]   item_tag_reg;
    logic [dfp_pkg::TIME_W-1:0]  item_time_reg;

    logic                        show_reg, show_next;
    logic [dfp_pkg::TAG_W-1:0]   tag_reg, tag_next;
    logic [dfp_pkg::DROP_W-1:0]  drop_reg, drop_next;

    logic [AW-1:0]               rd_head, rd_tail;
    logic [dfp_pkg::TAG_W-1:0]   head_tag, tail_tag;
    logic [dfp_pkg::TIME_W-1:0]  head_time;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;

    logic [CW-1:0]               lim;
    logic [TW-1:0]               tok_inc;
    logic [dfp_pkg::TIME_W-1:0]  dt_head, dt_last, grace_ext;
    logic [DW-1:0]               flush_cnt;
    logic [AW-1:0]               arr_head;
    logic [CW-1:0]               arr_count;

    function automatic logic [AW-1:0] slot_at(logic [AW-1:0] base, logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return AW'(sum);
    endfunction

    assign rd_head = head_reg;
    assign rd_tail = slot_at(head_reg, count_reg - CW'(1));

    dfp_ram #(.WIDTH(dfp_pkg::TAG_W), .DEPTH(QUEUE_DEPTH)) u_tag_head (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_tag_reg),
        .rd_addr (rd_head),
        .rd_data (head_tag)
    );

    dfp_ram #(.WIDTH(dfp_pkg::TAG_W), .DEPTH(QUEUE_DEPTH)) u_tag_tail (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_tag_reg),
        .rd_addr (rd_tail),
        .rd_data (tail_tag)
    );

    dfp_ram #(.WIDTH(dfp_pkg::TIME_W), .DEPTH(QUEUE_DEPTH)) u_time (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_time_reg),
        .rd_addr (rd_head),
        .rd_data (head_time)
    );

    always_comb begin
        if (limit_reg == '0) begin
            lim = CW'(1);
        end else if (int'(limit_reg) > QUEUE_DEPTH) begin
            lim = CW'(QUEUE_DEPTH);
        end else begin
            lim = CW'(limit_reg);
        end
    end

    always_comb begin
        tok_inc   = (tok_reg < (TW'(lim) + TW'(1))) ? tok_reg + TW'(1) : tok_reg;
        grace_ext = dfp_pkg::TIME_W'(grace_reg);
        dt_head   = item_time_reg - head_time;
        dt_last   = item_time_reg - last_reg;
        flush_cnt = DW'(count_reg) - DW'(1);

        tok_next   = tok_reg;
        head_next  = head_reg;
        count_next = count_reg;
        last_next  = last_reg;
        show_next  = 1'b0;
        tag_next   = '0;
        drop_next  = '0;
        wr_en      = 1'b0;
        arr_head   = head_reg;
        arr_count  = count_reg;

        if (item_cmd_reg == dfp_pkg::CMD_FRAME) begin
            if (tok_reg != '0 && grace_reg == '0) begin
                tok_next  = tok_reg - TW'(1);
                show_next = 1'b1;
                tag_next  = item_tag_reg;
            end else begin
                if (count_reg >= lim && count_reg != '0) begin
                    arr_head  = slot_at(head_reg, CW'(1));
                    arr_count = count_reg - CW'(1);
                    drop_next = 3'd1;
                end
                wr_en      = cmd.commit;
                head_next  = arr_head;
                count_next = arr_count + CW'(1);
            end
        end else begin
            tok_next = tok_inc;
            if (count_reg != '0 && tok_inc != '0 && dt_head >= grace_ext) begin
                tok_next   = tok_inc - TW'(1);
                show_next  = 1'b1;
                tag_next   = head_tag;
                head_next  = slot_at(head_reg, CW'(1));
                count_next = count_reg - CW'(1);
                last_next  = item_time_reg;
            end else if (count_reg != '0 && dt_last >= grace_ext) begin
                if (tok_inc != '0) begin
                    tok_next = tok_inc - TW'(1);
                end
                show_next  = 1'b1;
                tag_next   = tail_tag;
                drop_next  = (flush_cnt > DW'(7)) ? dfp_pkg::DROP_MAX : 3'(flush_cnt);
                count_next = '0;
                head_next  = '0;
                last_next  = item_time_reg;
            end
        end
        wr_addr = slot_at(arr_head, arr_count);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= dfp_pkg::QUEUE_LIMIT_RESET;
            grace_reg <= dfp_pkg::GRACE_RESET;
            tok_reg   <= '0;
            head_reg  <= '0;
            count_reg <= '0;
            last_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    dfp_pkg::REG_QUEUE_LIMIT: limit_reg <= cfg_wdata[dfp_pkg::LIMIT_W-1:0];
                    dfp_pkg::REG_GRACE_TIME:  grace_reg <= cfg_wdata;
                endcase
            end
            if (cmd.commit) begin
                tok_reg   <= tok_next;
                head_reg  <= head_next;
                count_reg <= count_next;
                last_reg  <= last_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_cmd_reg  <= in_cmd;
            item_tag_reg  <= in_tag;
            item_time_reg <= in_time;
        end
        if (cmd.commit) begin
            show_reg <= show_next;
            tag_reg  <= tag_next;
            drop_reg <= drop_next;
        end
    end

    assign out_show = show_reg;
    assign out_tag  = tag_reg;
    assign out_drop = drop_reg;

endmodule

// ===== design/dfp_checker.sv =====
// ----------------------------------------------------------------------------
// Display frame pacer checker
// Port-level properties of the pacer, bound to the top level.
// ----------------------------------------------------------------------------
`include "display_frame_pacer_unit_defines.svh"

module dfp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dfp_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tuser
);

    `DFP_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `DFP_ASSERT_NEXT(a_one_event, s_tvalid && s_tready, !s_tready, "second event taken while one is in flight")
    `DFP_ASSERT_NOW(a_rise_idle, $rose(m_tvalid), s_tready, "result issued without returning to idle")
    `DFP_ASSERT_NOW(a_no_show_tag, m_tvalid && !m_tuser, m_tdata[7:0] == 8'd0, "tag set without a show")
    `DFP_ASSERT_NOW(a_no_show_drop, m_tvalid && !m_tuser, m_tdata[10:9] == 2'd0, "flush drop without a show")

endmodule

bind display_frame_pacer_unit dfp_checker u_dfp_checker (.*);
